// ===== hw/rtl/lrf_pkg.sv =====
// Shared types, constants and field layout for the line raster frame buffer.
// Used by lrf_stepper and line_raster_framebuffer; depends on nothing.
package lrf_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_PAGES   = 8;
    localparam int SCREEN_ROWS    = 8 * SCREEN_PAGES;
    localparam int STORE_BYTES    = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int ADDR_W         = $clog2(STORE_BYTES);

    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 10;
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int BAL_W  = 10;
    localparam int CALC_W = 16;

    // tdata layout, lowest bit first
    localparam int SX_LSB  = 0;
    localparam int SY_LSB  = SX_LSB + X_W;
    localparam int EX_LSB  = SY_LSB + Y_W;
    localparam int EY_LSB  = EX_LSB + X_W;
    localparam int OP_LSB  = EY_LSB + Y_W;
    localparam int IDX_LSB = OP_LSB + OP_W;
    localparam int IN_BITS = IDX_LSB + IDX_W;
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_LINE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [OP_W-1:0] PIX_SET = 2'd0;
    localparam logic [OP_W-1:0] PIX_CLR = 2'd1;
    localparam logic [OP_W-1:0] PIX_INV = 2'd2;
    localparam logic [OP_W-1:0] PIX_OVR = 2'd3;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LINE_RD,
        ST_LINE_WR,
        ST_CLEAR,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [X_W-1:0] start_x;
        logic [Y_W-1:0] start_y;
        logic [X_W-1:0] end_x;
        logic [Y_W-1:0] end_y;
    } line_cmd_t;

    typedef struct packed {
        logic load;
        logic advance;
    } step_ctl_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           last;
    } point_t;

endpackage

// ===== hw/rtl/line_raster_framebuffer.sv =====
// Line raster frame buffer top: command sequencer, frame store and output register.
// Depends on lrf_pkg and lrf_stepper.
// Sequence: line reads then writes each pixel (ST_LINE_RD, ST_LINE_WR), read passes ST_READ
//   and ST_READ_DATA, clear zeroes all store bytes, unused command goes straight to ST_DONE.
// Throughput: one command at a time, accepted in the cycle after the previous result loads.
// Reset: a clearing pass zeroes all STORE_BYTES (1024) store bytes with s_axis_tready low.
module line_raster_framebuffer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_x, start_y, end_x, end_y, pixel_op, read_index, zero fill
    input  logic [lrf_pkg::IN_W-1:0]      s_axis_tdata,
    // cmd
    input  logic [lrf_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_byte
    output logic [lrf_pkg::BYTE_W-1:0]    m_axis_tdata
);

    lrf_pkg::state_t state_reg, state_next;

    logic [lrf_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [lrf_pkg::OP_W-1:0]   op_reg;
    logic [lrf_pkg::IDX_W-1:0]  idx_reg;
    logic [lrf_pkg::BYTE_W-1:0] result_reg, result_next;
    logic                       out_valid_reg, out_valid_next;
    logic [lrf_pkg::BYTE_W-1:0] out_data_reg;

    logic [lrf_pkg::BYTE_W-1:0] mem [lrf_pkg::STORE_BYTES];
    logic [lrf_pkg::BYTE_W-1:0] mem_rdata_reg;
    logic                       mem_we;
    logic [lrf_pkg::ADDR_W-1:0] mem_addr;
    logic [lrf_pkg::BYTE_W-1:0] mem_wdata;

    lrf_pkg::step_ctl_t  step_ctl;
    lrf_pkg::line_cmd_t  line;
    lrf_pkg::point_t     pt;

    logic                        in_xfer, out_xfer, out_load, clr_last;
    logic [lrf_pkg::CALC_W-1:0]  pix_calc, idx_calc;
    logic [lrf_pkg::ADDR_W-1:0]  pix_addr, idx_addr;
    logic                        pix_ok, idx_ok;
    logic [lrf_pkg::BYTE_W-1:0]  pix_bit, pix_byte;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign clr_last = clr_cnt_reg == lrf_pkg::ADDR_W'(lrf_pkg::STORE_BYTES - 1);

    assign line.start_x = s_axis_tdata[lrf_pkg::SX_LSB +: lrf_pkg::X_W];
    assign line.start_y = s_axis_tdata[lrf_pkg::SY_LSB +: lrf_pkg::Y_W];
    assign line.end_x   = s_axis_tdata[lrf_pkg::EX_LSB +: lrf_pkg::X_W];
    assign line.end_y   = s_axis_tdata[lrf_pkg::EY_LSB +: lrf_pkg::Y_W];

    lrf_stepper u_stepper
    (
        .clk  (clk),
        .ctl  (step_ctl),
        .line (line),
        .pt   (pt)
    );

    always_comb
    begin
        pix_ok   = (lrf_pkg::CALC_W'(pt.x) < lrf_pkg::CALC_W'(lrf_pkg::SCREEN_COLUMNS))
                && (lrf_pkg::CALC_W'(pt.y) < lrf_pkg::CALC_W'(lrf_pkg::SCREEN_ROWS));
        pix_calc = lrf_pkg::CALC_W'(pt.y >> 3) * lrf_pkg::CALC_W'(lrf_pkg::SCREEN_COLUMNS)
                 + lrf_pkg::CALC_W'(pt.x);
        pix_addr = lrf_pkg::ADDR_W'(pix_calc);
        idx_calc = lrf_pkg::CALC_W'(idx_reg);
        idx_ok   = idx_calc < lrf_pkg::CALC_W'(lrf_pkg::STORE_BYTES);
        idx_addr = lrf_pkg::ADDR_W'(idx_calc);
        pix_bit  = lrf_pkg::BYTE_W'(1) << pt.y[2:0];
        case (op_reg)
            lrf_pkg::PIX_SET: pix_byte = mem_rdata_reg | pix_bit;
            lrf_pkg::PIX_CLR: pix_byte = mem_rdata_reg & ~pix_bit;
            lrf_pkg::PIX_INV: pix_byte = mem_rdata_reg ^ pix_bit;
            default:          pix_byte = pix_bit;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrf_pkg::ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = lrf_pkg::ST_IDLE;
                end
            end
            lrf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (s_axis_tuser)
                        lrf_pkg::CMD_LINE:  state_next = lrf_pkg::ST_LINE_RD;
                        lrf_pkg::CMD_READ:  state_next = lrf_pkg::ST_READ;
                        lrf_pkg::CMD_CLEAR: state_next = lrf_pkg::ST_CLEAR;
                        default:            state_next = lrf_pkg::ST_DONE;
                    endcase
                end
            end
            lrf_pkg::ST_LINE_RD:   state_next = lrf_pkg::ST_LINE_WR;
            lrf_pkg::ST_LINE_WR:
            begin
                state_next = pt.last ? lrf_pkg::ST_DONE : lrf_pkg::ST_LINE_RD;
            end
            lrf_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = lrf_pkg::ST_DONE;
                end
            end
            lrf_pkg::ST_READ:      state_next = lrf_pkg::ST_READ_DATA;
            lrf_pkg::ST_READ_DATA: state_next = lrf_pkg::ST_DONE;
            lrf_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = lrf_pkg::ST_IDLE;
                end
            end
            default:               state_next = lrf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready    = 1'b0;
        mem_we           = 1'b0;
        mem_addr         = pix_addr;
        mem_wdata        = pix_byte;
        step_ctl.load    = 1'b0;
        step_ctl.advance = 1'b0;
        result_next      = result_reg;
        clr_cnt_next     = clr_cnt_reg;
        out_load         = 1'b0;
        unique case (state_reg)
            lrf_pkg::ST_INIT, lrf_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            lrf_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                step_ctl.load = s_axis_tvalid && (s_axis_tuser == lrf_pkg::CMD_LINE);
                result_next   = '0;
            end
            lrf_pkg::ST_LINE_RD:
            begin
                mem_addr = pix_addr;
            end
            lrf_pkg::ST_LINE_WR:
            begin
                mem_we           = pix_ok;
                step_ctl.advance = !pt.last;
            end
            lrf_pkg::ST_READ:
            begin
                mem_addr = idx_addr;
            end
            lrf_pkg::ST_READ_DATA:
            begin
                result_next = idx_ok ? mem_rdata_reg : '0;
            end
            lrf_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (out_xfer ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (in_xfer)
        begin
            op_reg  <= s_axis_tdata[lrf_pkg::OP_LSB +: lrf_pkg::OP_W];
            idx_reg <= s_axis_tdata[lrf_pkg::IDX_LSB +: lrf_pkg::IDX_W];
        end
        if (out_load)
        begin
            out_data_reg <= result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrf_pkg::ST_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/lrf_stepper.sv =====
// Bresenham point stepper: one add and one sign test per advance.
// Depends on lrf_pkg.
module lrf_stepper
(
    input  logic                 clk,
    input  lrf_pkg::step_ctl_t   ctl,
    input  lrf_pkg::line_cmd_t   line,
    output lrf_pkg::point_t      pt
);

    logic [lrf_pkg::X_W-1:0]          x_reg, x_next, ex_reg;
    logic [lrf_pkg::Y_W-1:0]          y_reg, y_next, ey_reg;
    logic                             sx_neg_reg, sy_neg_reg, xmaj_reg;
    logic signed [lrf_pkg::BAL_W-1:0] bal_reg, bal_next;
    logic signed [lrf_pkg::BAL_W-1:0] inc_lo_reg, inc_hi_reg;

    logic [lrf_pkg::X_W-1:0]          dx, dy, maj_d, min_d;
    logic                             sx_neg, sy_neg, xmaj;
    logic signed [lrf_pkg::BAL_W-1:0] maj2, min2;
    logic [lrf_pkg::X_W-1:0]          x_step;
    logic [lrf_pkg::Y_W-1:0]          y_step;
    logic                             minor_move;

    always_comb
    begin
        sx_neg = line.end_x < line.start_x;
        sy_neg = line.end_y < line.start_y;
        dx     = sx_neg ? line.start_x - line.end_x : line.end_x - line.start_x;
        dy     = lrf_pkg::X_W'(sy_neg ? line.start_y - line.end_y
                                      : line.end_y - line.start_y);
        xmaj   = dx >= dy;
        maj_d  = xmaj ? dx : dy;
        min_d  = xmaj ? dy : dx;
        maj2   = $signed({{(lrf_pkg::BAL_W-lrf_pkg::X_W-1){1'b0}}, maj_d, 1'b0});
        min2   = $signed({{(lrf_pkg::BAL_W-lrf_pkg::X_W-1){1'b0}}, min_d, 1'b0});
    end

    always_comb
    begin
        x_step     = sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
        y_step     = sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
        minor_move = !bal_reg[lrf_pkg::BAL_W-1];
        x_next     = x_reg;
        y_next     = y_reg;
        bal_next   = bal_reg + (minor_move ? inc_hi_reg : inc_lo_reg);
        if (xmaj_reg)
        begin
            x_next = x_step;
            if (minor_move)
            begin
                y_next = y_step;
            end
        end
        else
        begin
            y_next = y_step;
            if (minor_move)
            begin
                x_next = x_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg      <= line.start_x;
            y_reg      <= line.start_y;
            ex_reg     <= line.end_x;
            ey_reg     <= line.end_y;
            sx_neg_reg <= sx_neg;
            sy_neg_reg <= sy_neg;
            xmaj_reg   <= xmaj;
            bal_reg    <= min2 - $signed({{(lrf_pkg::BAL_W-lrf_pkg::X_W){1'b0}}, maj_d});
            inc_lo_reg <= min2;
            inc_hi_reg <= min2 - maj2;
        end
        else if (ctl.advance)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            bal_reg <= bal_next;
        end
    end

    assign pt.x    = x_reg;
    assign pt.y    = y_reg;
    assign pt.last = xmaj_reg ? (x_reg == ex_reg) : (y_reg == ey_reg);

endmodule
